>>> src/linear_interp_downsampler_defines.svh
// Assertion macros for the linear interpolation downsampler.
// Included by the top level; depends on nothing else.
`ifndef LINEAR_INTERP_DOWNSAMPLER_DEFINES_SVH
`define LINEAR_INTERP_DOWNSAMPLER_DEFINES_SVH

// The condition implies the expression in the same cycle.
`define LID_ASSERT_IMPLY(label, clock, resetn, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (expr)) \
        else $error(msg);

// The condition implies the expression in the next cycle.
`define LID_ASSERT_NEXT(label, clock, resetn, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> src/lid_pkg.sv
// Shared types, constants and helpers of the linear interpolation downsampler.
// Used by lid_arith and linear_interp_downsampler; depends on nothing.
package lid_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int IN_STEP_W   = 12;
    localparam int OUT_STEP_W  = 10;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int PHASE_W     = 13;
    localparam int CALC_W      = 15;

    localparam logic [PHASE_W-1:0]     PHASE_MAX      = 13'd8191;
    localparam logic [IN_STEP_W-1:0]   IN_STEP_RESET  = 12'd441;
    localparam logic [OUT_STEP_W-1:0]  OUT_STEP_RESET = 10'd160;

    localparam logic [CFG_INDEX_W-1:0] CFG_IN_STEP  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_STEP = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t pcm_sample;
        logic    buffer_last;
    } in_item_t;

    typedef struct packed {
        sample_t out_sample;
        logic    sample_valid;
        logic    buffer_end;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_CALC,
        ST_FINISH
    } lid_state_t;

    typedef enum logic [2:0] {
        AR_IDLE,
        AR_MUL0,
        AR_MUL1,
        AR_PREP,
        AR_DIV
    } arith_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

    // Limits a phase value to the range 1 .. PHASE_MAX.
    function automatic logic [PHASE_W-1:0] clamp_phase(input logic signed [CALC_W-1:0] v);
        logic [PHASE_W-1:0] r;
        if (v < $signed(CALC_W'(1)))
        begin
            r = PHASE_W'(1);
        end
        else if (v > $signed({{(CALC_W-PHASE_W){1'b0}}, PHASE_MAX}))
        begin
            r = PHASE_MAX;
        end
        else
        begin
            r = v[PHASE_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> src/lid_arith.sv
// Shared multiplier and serial rounding divider of the downsampler.
// Depends on lid_pkg for sample types, widths and sequencer states.
module lid_arith (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  lid_pkg::sample_t                 prev_sample,
    input  lid_pkg::sample_t                 cur_sample,
    input  logic [lid_pkg::OUT_STEP_W-1:0]   phase,
    input  logic [lid_pkg::OUT_STEP_W-1:0]   divisor,
    output lid_pkg::sample_t                 quotient,
    output lid_pkg::arith_stat_t             stat
);

    localparam int SB    = lid_pkg::SAMPLE_BITS;
    localparam int OW    = lid_pkg::OUT_STEP_W;
    localparam int ACC_W = SB + OW + 1;
    localparam int REM_W = OW + 1;
    localparam int CNT_W = $clog2(SB);

    lid_pkg::arith_state_t state_reg, state_next;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [SB-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;

    logic signed [SB-1:0]    mul_x;
    logic signed [OW:0]      mul_y;
    logic signed [ACC_W-1:0] product;
    logic [ACC_W-1:0]        mag;
    logic [ACC_W-1:0]        dividend;
    logic [REM_W:0]          trial;
    logic [REM_W:0]          den2;
    logic                    fits;
    logic                    last_step;
    logic [SB-1:0]           quo_sel;

    // The one multiplier serves both interpolation terms in turn.
    assign mul_x   = (state_reg == lid_pkg::AR_MUL0) ? prev_sample : cur_sample;
    assign mul_y   = (state_reg == lid_pkg::AR_MUL0) ? $signed({1'b0, divisor - phase})
                                                     : $signed({1'b0, phase});
    assign product = mul_x * mul_y;

    // Rounding to nearest is done on the magnitude: (2|x| + d) / (2d).
    assign mag      = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign dividend = {mag[ACC_W-2:0], 1'b0} + ACC_W'(divisor);

    assign trial     = {rem_reg, quo_reg[SB-1]};
    assign den2      = {1'b0, divisor, 1'b0};
    assign fits      = (trial >= den2);
    assign last_step = (cnt_reg == CNT_W'(SB - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lid_pkg::AR_IDLE:
            begin
                if (start)
                begin
                    state_next = lid_pkg::AR_MUL0;
                end
            end
            lid_pkg::AR_MUL0: state_next = lid_pkg::AR_MUL1;
            lid_pkg::AR_MUL1: state_next = lid_pkg::AR_PREP;
            lid_pkg::AR_PREP: state_next = lid_pkg::AR_DIV;
            lid_pkg::AR_DIV:
            begin
                if (last_step)
                begin
                    state_next = lid_pkg::AR_IDLE;
                end
            end
            default: state_next = lid_pkg::AR_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (state_reg)
            lid_pkg::AR_MUL0:
            begin
                acc_next = product;
            end
            lid_pkg::AR_MUL1:
            begin
                acc_next = acc_reg + product;
            end
            lid_pkg::AR_PREP:
            begin
                // The quotient fits in SB bits, so only SB steps are needed.
                neg_next = acc_reg[ACC_W-1];
                rem_next = dividend[ACC_W-1:SB];
                quo_next = dividend[SB-1:0];
                cnt_next = '0;
            end
            lid_pkg::AR_DIV:
            begin
                rem_next  = fits ? REM_W'(trial - den2) : trial[REM_W-1:0];
                quo_next  = {quo_reg[SB-2:0], fits};
                cnt_next  = cnt_reg + CNT_W'(1);
                done_next = last_step;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lid_pkg::AR_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quo_sel     = neg_reg ? (~quo_reg + SB'(1)) : quo_reg;
    assign quotient    = $signed(quo_sel);
    assign stat.busy   = (state_reg != lid_pkg::AR_IDLE);
    assign stat.done   = done_reg;

endmodule

>>> src/linear_interp_downsampler.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_data (pcm_sample, buffer_last)
// out       output     out_valid/out_ready  out_data (out_sample, sample_valid, buffer_end)
// cfg       input      cfg_we               cfg_index, cfg_data (in_step, out_step)
//
// A sample that lands an output passes through start, the multiplies of both terms,
// set-up, 16 divider steps, quotient hand-back and finish, and only then is the next
// sample taken. Any other sample goes from acceptance straight to finish before the
// next is taken. Reset clears the phase and pending state and loads the default rate
// ratio. A result waiting in the output register stalls only the finish of the next
// transaction; that sample is still accepted and worked on.
// Top level; depends on lid_pkg, lid_arith and the defines header.
module linear_interp_downsampler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lid_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lid_pkg::out_item_t                out_data,
    input  logic                              cfg_we,
    input  logic [lid_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lid_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "linear_interp_downsampler_defines.svh"

    localparam int IW = lid_pkg::IN_STEP_W;
    localparam int OW = lid_pkg::OUT_STEP_W;
    localparam int PW = lid_pkg::PHASE_W;
    localparam int CW = lid_pkg::CALC_W;

    lid_pkg::lid_state_t state_reg, state_next;

    logic [IW-1:0]        in_step_reg, in_step_next;
    logic [OW-1:0]        out_step_reg, out_step_next;

    lid_pkg::sample_t     previous_sample_reg, previous_sample_next;
    logic                 have_previous_reg, have_previous_next;
    logic [PW-1:0]        next_phase_reg, next_phase_next;
    logic [PW-1:0]        release_phase_reg, release_phase_next;
    lid_pkg::sample_t     pending_sample_reg, pending_sample_next;
    logic                 pending_valid_reg, pending_valid_next;

    lid_pkg::sample_t     cur_reg;
    lid_pkg::sample_t     prev_op_reg;
    logic                 last_reg;
    logic                 calc_reg;
    logic [PW-1:0]        a_reg;

    logic                 out_valid_reg, out_valid_next;
    lid_pkg::out_item_t   out_data_reg, out_data_next;

    logic [OW-1:0]        o_eff;
    logic [IW-1:0]        n_eff;
    logic [PW-1:0]        a_eff;
    logic                 accept;
    logic                 fin_go;
    logic                 arith_start;
    lid_pkg::sample_t     arith_q;
    lid_pkg::arith_stat_t arith_stat;

    logic signed [CW-1:0] rel_diff;
    logic signed [CW-1:0] calc_rel;
    logic signed [CW-1:0] a_sum;
    logic signed [CW-1:0] a_fin;
    logic                 emit;
    lid_pkg::sample_t     emit_val;

    // A zero out_step counts as one, and in_step never drops below out_step.
    assign o_eff  = (out_step_reg == '0) ? OW'(1) : out_step_reg;
    assign n_eff  = (in_step_reg < IW'(o_eff)) ? IW'(o_eff) : in_step_reg;
    assign a_eff  = have_previous_reg ? next_phase_reg : PW'(o_eff);
    assign accept = in_valid && in_ready;
    assign fin_go = (state_reg == lid_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    lid_arith u_arith (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (arith_start),
        .prev_sample (prev_op_reg),
        .cur_sample  (cur_reg),
        .phase       (a_reg[OW-1:0]),
        .divisor     (o_eff),
        .quotient    (arith_q),
        .stat        (arith_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lid_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (a_eff <= PW'(o_eff)) ? lid_pkg::ST_START
                                                       : lid_pkg::ST_FINISH;
                end
            end
            lid_pkg::ST_START: state_next = lid_pkg::ST_CALC;
            lid_pkg::ST_CALC:
            begin
                if (arith_stat.done)
                begin
                    state_next = lid_pkg::ST_FINISH;
                end
            end
            lid_pkg::ST_FINISH:
            begin
                if (fin_go)
                begin
                    state_next = lid_pkg::ST_IDLE;
                end
            end
            default: state_next = lid_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        arith_start = 1'b0;
        case (state_reg)
            lid_pkg::ST_IDLE:  in_ready = 1'b1;
            lid_pkg::ST_START: arith_start = 1'b1;
            default:
            begin
                in_ready    = 1'b0;
                arith_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        in_step_next  = in_step_reg;
        out_step_next = out_step_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lid_pkg::CFG_IN_STEP:  in_step_next  = cfg_data[IW-1:0];
                lid_pkg::CFG_OUT_STEP: out_step_next = cfg_data[OW-1:0];
                default:
                begin
                    in_step_next  = in_step_reg;
                    out_step_next = out_step_reg;
                end
            endcase
        end
    end

    // Release of the pending output, then the new output, then the phase update.
    always_comb
    begin
        rel_diff = $signed(CW'(release_phase_reg)) - $signed(CW'(o_eff));
        calc_rel = $signed(CW'(a_reg)) + $signed(CW'(n_eff)) - $signed(CW'({o_eff, 1'b0}));
        a_sum    = calc_reg ? ($signed(CW'(a_reg)) + $signed(CW'(n_eff)))
                            : $signed(CW'(a_reg));
        a_fin    = a_sum - $signed(CW'(o_eff));

        emit                 = 1'b0;
        emit_val             = '0;
        pending_valid_next   = pending_valid_reg;
        pending_sample_next  = pending_sample_reg;
        release_phase_next   = release_phase_reg;

        if (pending_valid_reg)
        begin
            if (rel_diff <= $signed(CW'(0)))
            begin
                emit               = 1'b1;
                emit_val           = pending_sample_reg;
                pending_valid_next = 1'b0;
            end
            else
            begin
                release_phase_next = rel_diff[PW-1:0];
            end
        end

        if (calc_reg)
        begin
            // Two releases cannot share one input, so a clash keeps the new one pending.
            if ((calc_rel <= $signed(CW'(0))) && !emit)
            begin
                emit     = 1'b1;
                emit_val = arith_q;
            end
            else
            begin
                pending_sample_next = arith_q;
                pending_valid_next  = 1'b1;
                release_phase_next  = lid_pkg::clamp_phase(calc_rel);
            end
        end

        next_phase_next      = lid_pkg::clamp_phase(a_fin);
        previous_sample_next = cur_reg;
        have_previous_next   = 1'b1;

        if (last_reg)
        begin
            previous_sample_next = '0;
            have_previous_next   = 1'b0;
            next_phase_next      = '0;
            release_phase_next   = '0;
            pending_sample_next  = '0;
            pending_valid_next   = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (fin_go && (emit || last_reg))
        begin
            out_valid_next              = 1'b1;
            out_data_next.out_sample    = emit ? emit_val : '0;
            out_data_next.sample_valid  = emit;
            out_data_next.buffer_end    = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= lid_pkg::ST_IDLE;
            in_step_reg         <= lid_pkg::IN_STEP_RESET;
            out_step_reg        <= lid_pkg::OUT_STEP_RESET;
            previous_sample_reg <= '0;
            have_previous_reg   <= 1'b0;
            next_phase_reg      <= '0;
            release_phase_reg   <= '0;
            pending_sample_reg  <= '0;
            pending_valid_reg   <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_step_reg   <= in_step_next;
            out_step_reg  <= out_step_next;
            out_valid_reg <= out_valid_next;
            if (fin_go)
            begin
                previous_sample_reg <= previous_sample_next;
                have_previous_reg   <= have_previous_next;
                next_phase_reg      <= next_phase_next;
                release_phase_reg   <= release_phase_next;
                pending_sample_reg  <= pending_sample_next;
                pending_valid_reg   <= pending_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            cur_reg     <= in_data.pcm_sample;
            last_reg    <= in_data.buffer_last;
            a_reg       <= a_eff;
            calc_reg    <= (a_eff <= PW'(o_eff));
            prev_op_reg <= have_previous_reg ? previous_sample_reg : in_data.pcm_sample;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `LID_ASSERT_IMPLY(a_start_when_free, clk, rst_n, arith_start, !arith_stat.busy,
        "arith started while busy")
    `LID_ASSERT_IMPLY(a_phase_set, clk, rst_n, have_previous_reg, next_phase_reg != '0,
        "next phase is zero")
    `LID_ASSERT_IMPLY(a_release_set, clk, rst_n, pending_valid_reg, release_phase_reg != '0,
        "release phase is zero")
    `LID_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_ready,
        "ready right after a transaction")

endmodule
